>>> design/hcbp_pkg.sv
package hcbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 40;
    localparam int CNT_W  = 3;
    localparam int LEFT_W = 3;
    localparam int SYM_W  = 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } out_t;

    typedef struct packed {
        logic load;
        logic read;
        logic build;
        logic flush;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sym_ok;
        logic pend_empty;
        logic build_bytes;
        logic left_one;
        logic out_free;
    } stat_t;

endpackage

>>> design/huffman_code_bit_packer.sv
// Channel  Direction  Payload  Handshake
// in       input      in_t     in_valid / in_ready
// out      output     out_t    out_valid / out_ready
//
// Load: code RAM write. Flush: 1 byte beat. Encode: code RAM read, then bit
// merge, then one byte beat per completed byte, up to 4.
// rst_n clears the pending bits and the output valid flag; the code RAM is not
// cleared and must be loaded before use.
// A stalled output holds the emit sequence; the last beat may wait in the
// single byte output register while the next item is taken.
module huffman_code_bit_packer import hcbp_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t  cmd;
    stat_t stat;

    hcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .operation(in_data.operation),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcbp_dp #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

>>> design/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH  = 38,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/hcbp_ctrl.sv
module hcbp_ctrl import hcbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            cmd.load = stat.sym_ok;
                        end
                        OP_ENCODE:
                        begin
                            if (stat.sym_ok)
                            begin
                                cmd.read   = 1'b1;
                                state_next = ST_BUILD;
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (!stat.pend_empty)
                            begin
                                cmd.flush  = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                cmd.build  = 1'b1;
                state_next = stat.build_bytes ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.left_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> state_reg == ST_BUILD)
        else $error("encode lookup not followed by build");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("beat emitted into an occupied output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !in_ready)
        else $error("input taken while bytes still to emit");

endmodule

>>> design/hcbp_dp.sv
module hcbp_dp import hcbp_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  in_t  in_data,
    input  cmd_t cmd,
    output stat_t stat,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LIM    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int WORD_W = CODE_W + LEN_W;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    out_t              out_reg;
    out_t              out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [LEN_W-1:0]  len_sat;
    logic [WORD_W-1:0] rd_word;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    logic [CODE_W:0]   mask_wide;
    logic [CODE_W-1:0] code_masked;
    logic [LEN_W-1:0]  total;
    logic [ACC_W-1:0]  acc_built;

    assign len_sat = (in_data.code_length > LEN_W'(LIM)) ? LEN_W'(LIM) : in_data.code_length;

    hcbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SYMBOL_COUNT),
        .ADDR_W(ADDR_W)
    ) u_code_ram (
        .clk    (clk),
        .wr_en  (cmd.load),
        .wr_addr(in_data.symbol[ADDR_W-1:0]),
        .wr_data({len_sat, in_data.code_bits}),
        .rd_en  (cmd.read),
        .rd_addr(in_data.symbol[ADDR_W-1:0]),
        .rd_data(rd_word)
    );

    assign rd_code     = rd_word[CODE_W-1:0];
    assign rd_len      = rd_word[WORD_W-1:CODE_W];
    assign mask_wide   = ((CODE_W+1)'(1) << rd_len) - (CODE_W+1)'(1);
    assign code_masked = rd_code & mask_wide[CODE_W-1:0];
    assign total       = LEN_W'(cnt_reg) + rd_len;
    assign acc_built   = ACC_W'(acc_reg[BYTE_W-1:0])
                       | (ACC_W'(code_masked) << cnt_reg);

    assign stat.sym_ok      = {1'b0, in_data.symbol} < (SYM_W+1)'(SYMBOL_COUNT);
    assign stat.pend_empty  = (cnt_reg == '0);
    assign stat.build_bytes = (total[LEN_W-1:CNT_W] != '0);
    assign stat.left_one    = (left_reg == LEFT_W'(1));
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.build)
        begin
            acc_next  = acc_built;
            cnt_next  = total[CNT_W-1:0];
            left_next = LEFT_W'(total[LEN_W-1:CNT_W]);
        end
        if (cmd.flush)
        begin
            cnt_next  = '0;
            left_next = LEFT_W'(1);
        end
        if (cmd.emit)
        begin
            out_next.out_byte    = acc_reg[BYTE_W-1:0];
            out_next.last_of_run = (left_reg == LEFT_W'(1));
            out_valid_next       = 1'b1;
            acc_next             = acc_reg >> BYTE_W;
            left_next            = left_reg - LEFT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> left_reg != '0)
        else $error("beat emitted with no byte left");

    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg == '0 |-> acc_reg[ACC_W-1:BYTE_W] == '0)
        else $error("stray bits above the pending byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg == '0 |-> (acc_reg[BYTE_W-1:0] >> cnt_reg) == '0)
        else $error("pending byte holds bits above its count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build |=> left_reg <= LEFT_W'(4))
        else $error("more than four bytes from one symbol");

endmodule
